FILE: rtl/ifmt_pkg.sv
// Package with the item types, character codes and control store of the integer field formatter.
`timescale 1ns / 1ps

package ifmt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 62;
    localparam int BCD_DIGITS = 10;
    localparam int DIG_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 7;
    localparam int UPC_W      = 4;
    localparam int DAB_W      = $clog2(VALUE_BITS);

    // Digit counts of a full-width value in each base.
    localparam logic [CNT_W-1:0] NDIG_BIN = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] NDIG_OCT = CNT_W'((VALUE_BITS + 2) / 3);
    localparam logic [CNT_W-1:0] NDIG_HEX = CNT_W'((VALUE_BITS + 3) / 4);
    localparam logic [CNT_W-1:0] NDIG_DEC = CNT_W'(BCD_DIGITS);

    // Conversion kinds.
    localparam logic [2:0] KIND_DEC = 3'd0;
    localparam logic [2:0] KIND_BIN = 3'd1;
    localparam logic [2:0] KIND_OCT = 3'd2;
    localparam logic [2:0] KIND_HEX = 3'd3;
    localparam logic [2:0] KIND_PTR = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [VALUE_BITS-1:0] value;
        logic                  alt_prefix;
        logic                  zero_pad;
        logic                  left_justify;
        logic                  space_sign;
        logic                  plus_sign;
        logic                  caps;
        logic [5:0]            field_width;
        logic [5:0]            min_digits;
        logic                  min_digits_given;
    } t_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_res;

    typedef enum logic [3:0] {
        ACT_WAIT,
        ACT_NONE,
        ACT_DABBLE,
        ACT_NORM,
        ACT_SETUP,
        ACT_LEAD,
        ACT_PFX,
        ACT_ZERO,
        ACT_DIG,
        ACT_TRAIL
    } t_act;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_BAD_KIND,
        C_NOT_DEC,
        C_DAB_MORE,
        C_NORM_MORE,
        C_RUN_MORE
    } t_cond;

    typedef struct packed {
        t_act             act;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_ucode;

    // Step addresses of the program.
    localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_CHECK  = 4'd1;
    localparam logic [UPC_W-1:0] UPC_BRANCH = 4'd2;
    localparam logic [UPC_W-1:0] UPC_DABBLE = 4'd3;
    localparam logic [UPC_W-1:0] UPC_NORM   = 4'd4;
    localparam logic [UPC_W-1:0] UPC_SETUP  = 4'd5;
    localparam logic [UPC_W-1:0] UPC_LEAD   = 4'd6;
    localparam logic [UPC_W-1:0] UPC_PFX    = 4'd7;
    localparam logic [UPC_W-1:0] UPC_ZERO   = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DIG    = 4'd9;
    localparam logic [UPC_W-1:0] UPC_TRAIL  = 4'd10;
    localparam logic [UPC_W-1:0] UPC_END    = 4'd11;

    // Control store: when the condition holds the step jumps to its target,
    // otherwise it falls through to the next step.
    function automatic t_ucode ucode_rom(input logic [UPC_W-1:0] pc);
        t_ucode w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, target: UPC_IDLE};
        case (pc)
            UPC_IDLE:   w = '{act: ACT_WAIT,   cond: C_NO_ACCEPT, target: UPC_IDLE};
            UPC_CHECK:  w = '{act: ACT_NONE,   cond: C_BAD_KIND,  target: UPC_IDLE};
            UPC_BRANCH: w = '{act: ACT_NONE,   cond: C_NOT_DEC,   target: UPC_NORM};
            UPC_DABBLE: w = '{act: ACT_DABBLE, cond: C_DAB_MORE,  target: UPC_DABBLE};
            UPC_NORM:   w = '{act: ACT_NORM,   cond: C_NORM_MORE, target: UPC_NORM};
            UPC_SETUP:  w = '{act: ACT_SETUP,  cond: C_NEVER,     target: UPC_IDLE};
            UPC_LEAD:   w = '{act: ACT_LEAD,   cond: C_RUN_MORE,  target: UPC_LEAD};
            UPC_PFX:    w = '{act: ACT_PFX,    cond: C_RUN_MORE,  target: UPC_PFX};
            UPC_ZERO:   w = '{act: ACT_ZERO,   cond: C_RUN_MORE,  target: UPC_ZERO};
            UPC_DIG:    w = '{act: ACT_DIG,    cond: C_RUN_MORE,  target: UPC_DIG};
            UPC_TRAIL:  w = '{act: ACT_TRAIL,  cond: C_RUN_MORE,  target: UPC_TRAIL};
            UPC_END:    w = '{act: ACT_NONE,   cond: C_ALWAYS,    target: UPC_IDLE};
            default:    w = '{act: ACT_NONE,   cond: C_ALWAYS,    target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/integer_field_formatter_top.sv
// Top level of the integer field formatter: control store sequencer, digit datapath and output register.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (t_req)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (t_res), one char
//
//  An item passes the check, branch, double-dabble (decimal only), leading-zero strip and
//  setup steps and the five runs: leading spaces, prefix, zeros, digits, trailing spaces.
//  An undefined kind goes back to idle from the check step. Only one item is in work at a
//  time, and the next can be taken while the final character still waits in the output register.
//  Reset is synchronous and active low; it returns the sequencer to its idle step.
//  A stalled output holds its character and the sequencer waits on that step.

module integer_field_formatter_top
    import ifmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_item
);

    logic [UPC_W-1:0]      r_pc, n_pc;
    t_req                  r_req, n_req;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [DIG_W-1:0]      r_dig, n_dig;
    logic                  r_neg, n_neg;
    logic [DAB_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_ndig, n_ndig;
    logic [CNT_W-1:0]      r_lead, n_lead;
    logic [1:0]            r_pfx, n_pfx;
    logic [7:0]            r_p0, n_p0;
    logic [7:0]            r_p1, n_p1;
    logic [CNT_W-1:0]      r_zero, n_zero;
    logic [CNT_W-1:0]      r_trail, n_trail;
    logic [CNT_W-1:0]      r_left, n_left;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out, n_out;

    t_ucode                uw;
    logic                  accept;
    logic                  can_emit;
    logic                  do_emit;
    logic                  emit_act;
    logic                  take;
    logic                  norm_more;
    logic                  run_more;
    logic [CNT_W-1:0]      cur_cnt;
    logic [7:0]            emit_ch;
    logic [3:0]            top_dig;
    logic [DIG_W-1:0]      dig_shl;
    logic [7:0]            dig_ch;
    logic [DIG_W-1:0]      bcd_adj;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    // Setup arithmetic.
    logic [CNT_W-1:0]      s_wid, s_digs, s_nreq, s_sum, s_pad, s_total;
    logic [1:0]            s_nextra;
    logic [7:0]            s_p0, s_p1;
    logic                  s_zpad, s_space, s_alt;

    assign uw         = ucode_rom(r_pc);
    assign o_in_stall = (uw.act != ACT_WAIT);
    assign accept     = i_in_valid && !o_in_stall;
    assign can_emit   = !r_out_valid || !i_out_stall;

    assign in_neg = (i_in_item.req_type == KIND_DEC) && i_in_item.value[VALUE_BITS-1];
    assign in_mag = in_neg ? (-i_in_item.value) : i_in_item.value;

    // Most significant digit of the digit register and the register shifted past it.
    always_comb begin
        case (r_req.req_type)
            KIND_BIN: begin
                top_dig = {3'b000, r_dig[DIG_W-1]};
                dig_shl = r_dig << 1;
            end
            KIND_OCT: begin
                top_dig = {1'b0, r_dig[DIG_W-1 -: 3]};
                dig_shl = r_dig << 3;
            end
            default: begin
                top_dig = r_dig[DIG_W-1 -: 4];
                dig_shl = r_dig << 4;
            end
        endcase
    end

    always_comb begin
        if (top_dig < 4'd10) begin
            dig_ch = CH_ZERO + {4'b0000, top_dig};
        end else begin
            dig_ch = (r_req.caps ? CH_UP_A : CH_LO_A) + {4'b0000, top_dig} - 8'd10;
        end
    end

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_dig[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_dig[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_dig[4*i +: 4];
            end
        end
    end

    assign norm_more = (top_dig == 4'd0) && (r_ndig != '0);

    // Run count and character of the current emission step.
    always_comb begin
        emit_act = 1'b1;
        case (uw.act)
            ACT_LEAD: begin
                cur_cnt = r_lead;
                emit_ch = CH_SPACE;
            end
            ACT_PFX: begin
                cur_cnt = {{(CNT_W-2){1'b0}}, r_pfx};
                emit_ch = r_p0;
            end
            ACT_ZERO: begin
                cur_cnt = r_zero;
                emit_ch = CH_ZERO;
            end
            ACT_DIG: begin
                cur_cnt = r_ndig;
                emit_ch = dig_ch;
            end
            ACT_TRAIL: begin
                cur_cnt = r_trail;
                emit_ch = CH_SPACE;
            end
            default: begin
                emit_act = 1'b0;
                cur_cnt  = '0;
                emit_ch  = CH_SPACE;
            end
        endcase
    end

    assign do_emit  = emit_act && (cur_cnt != '0) && can_emit;
    assign run_more = (cur_cnt != '0) && !(can_emit && (cur_cnt == CNT_W'(1)));

    always_comb begin
        case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !accept;
            C_BAD_KIND:  take = (r_req.req_type > KIND_PTR);
            C_NOT_DEC:   take = (r_req.req_type != KIND_DEC);
            C_DAB_MORE:  take = (r_cnt != '0);
            C_NORM_MORE: take = norm_more;
            C_RUN_MORE:  take = run_more;
            default:     take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + UPC_W'(1);
    end

    // Field layout: flag rules, sign or prefix, and the lengths of each run.
    always_comb begin
        s_wid  = (r_req.field_width > 6'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                     : CNT_W'(r_req.field_width);
        s_digs = (r_req.min_digits > 6'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                    : CNT_W'(r_req.min_digits);
        s_zpad  = r_req.zero_pad && !r_req.left_justify && !r_req.min_digits_given;
        s_space = r_req.space_sign && !r_req.plus_sign;
        s_alt   = (r_req.req_type == KIND_PTR) ||
                  (r_req.alt_prefix && (r_req.req_type != KIND_DEC));
        if (r_req.min_digits_given) begin
            s_nreq = (s_digs > r_ndig) ? s_digs : r_ndig;
        end else begin
            s_nreq = (r_ndig > CNT_W'(1)) ? r_ndig : CNT_W'(1);
        end
        s_nextra = 2'd0;
        s_p0     = CH_ZERO;
        s_p1     = CH_ZERO;
        if (r_neg) begin
            s_nextra = 2'd1;
            s_p0     = CH_MINUS;
        end else if (s_nreq == '0) begin
            s_nextra = 2'd0;
        end else if (r_req.plus_sign) begin
            s_nextra = 2'd1;
            s_p0     = CH_PLUS;
        end else if (s_space) begin
            s_nextra = 2'd1;
            s_p0     = CH_SPACE;
        end else if (s_alt && (r_ndig != '0)) begin
            // A nonzero value always leaves at least one significant digit.
            case (r_req.req_type)
                KIND_BIN: begin
                    s_nextra = 2'd2;
                    s_p1     = r_req.caps ? CH_UP_B : CH_LO_B;
                end
                KIND_OCT: begin
                    s_nextra = 2'd1;
                end
                default: begin
                    s_nextra = 2'd2;
                    s_p1     = r_req.caps ? CH_UP_X : CH_LO_X;
                end
            endcase
        end
        s_sum   = s_nreq + {{(CNT_W-2){1'b0}}, s_nextra};
        s_pad   = (s_wid > s_sum) ? (s_wid - s_sum) : '0;
        s_total = s_pad + s_sum;
    end

    always_comb begin
        n_req       = r_req;
        n_val       = r_val;
        n_dig       = r_dig;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_ndig      = r_ndig;
        n_lead      = r_lead;
        n_pfx       = r_pfx;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_zero      = r_zero;
        n_trail     = r_trail;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        case (uw.act)
            ACT_WAIT: begin
                if (accept) begin
                    n_req = i_in_item;
                    n_neg = in_neg;
                    n_val = in_mag;
                    n_cnt = DAB_W'(VALUE_BITS - 1);
                    case (i_in_item.req_type)
                        KIND_BIN: begin
                            n_dig  = {i_in_item.value, {(DIG_W-VALUE_BITS){1'b0}}};
                            n_ndig = NDIG_BIN;
                        end
                        KIND_OCT: begin
                            n_dig  = {1'b0, i_in_item.value, {(DIG_W-VALUE_BITS-1){1'b0}}};
                            n_ndig = NDIG_OCT;
                        end
                        KIND_DEC: begin
                            n_dig  = '0;
                            n_ndig = NDIG_DEC;
                        end
                        default: begin
                            n_dig  = {i_in_item.value, {(DIG_W-VALUE_BITS){1'b0}}};
                            n_ndig = NDIG_HEX;
                        end
                    endcase
                end
            end
            ACT_DABBLE: begin
                n_dig = {bcd_adj[DIG_W-2:0], r_val[VALUE_BITS-1]};
                n_val = r_val << 1;
                n_cnt = r_cnt - DAB_W'(1);
            end
            ACT_NORM: begin
                if (norm_more) begin
                    n_dig  = dig_shl;
                    n_ndig = r_ndig - CNT_W'(1);
                end
            end
            ACT_SETUP: begin
                n_lead  = (!r_req.left_justify && !s_zpad) ? s_pad : '0;
                n_pfx   = s_nextra;
                n_p0    = s_p0;
                n_p1    = s_p1;
                n_zero  = (s_zpad ? s_pad : '0) + (s_nreq - r_ndig);
                n_trail = r_req.left_justify ? s_pad : '0;
                n_left  = s_total;
            end
            default: begin
            end
        endcase
        if (do_emit) begin
            n_out_valid = 1'b1;
            n_out       = '{out_char: emit_ch, last: (r_left == CNT_W'(1))};
            n_left      = r_left - CNT_W'(1);
            case (uw.act)
                ACT_LEAD:  n_lead = r_lead - CNT_W'(1);
                ACT_PFX: begin
                    n_pfx = r_pfx - 2'd1;
                    n_p0  = r_p1;
                end
                ACT_ZERO:  n_zero = r_zero - CNT_W'(1);
                ACT_DIG: begin
                    n_ndig = r_ndig - CNT_W'(1);
                    n_dig  = dig_shl;
                end
                ACT_TRAIL: n_trail = r_trail - CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UPC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_val   <= n_val;
        r_dig   <= n_dig;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_ndig  <= n_ndig;
        r_lead  <= n_lead;
        r_pfx   <= n_pfx;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_zero  <= n_zero;
        r_trail <= n_trail;
        r_left  <= n_left;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/ifmt_checker.sv
// Port-level checker for the integer field formatter, bound to the top level.
`timescale 1ns / 1ps

module ifmt_port_props
    import ifmt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_item,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_res o_out_item
);

    // A held character stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output item changed while stalled");

    // Only one item is in work at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // While characters of an item remain, no new item may be taken.
    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> o_in_stall)
        else $error("input accepted before the last character was produced");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_field_formatter_top ifmt_port_props u_ifmt_port_props (.*);

FILE: tb/ifmt_checker.sv
// Checker of the integer field formatter: predicts each character from the accepted requests and compares.
`timescale 1ns / 1ps

module ifmt_checker
    import ifmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in_item,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_res i_out_item,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int CHAR_CAP = 64;

    t_res char_fifo[$];
    t_res want;
    int   fail_total = 0;

    // Builds the whole field of one request and queues its characters.
    function automatic void predict_chars(input t_req r);
        logic [7:0]            field_chars[$];
        logic [7:0]            digits[CHAR_CAP];
        logic [VALUE_BITS-1:0] radix;
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] rest;
        logic [7:0]            p0;
        logic [7:0]            p1;
        logic                  alt;
        logic                  zpad;
        logic                  space;
        logic                  neg;
        int                    width;
        int                    digs;
        int                    nsig;
        int                    nreq;
        int                    nextra;
        int                    pad;
        int                    digit_val;
        int                    n;
        t_res                  c;

        nsig   = 0;
        nextra = 0;
        neg    = 1'b0;
        p0     = '0;
        p1     = '0;
        width  = (int'(r.field_width) > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
        digs   = (int'(r.min_digits) > MAX_FIELD) ? MAX_FIELD : int'(r.min_digits);
        alt    = r.alt_prefix;
        case (r.req_type)
            KIND_DEC: begin
                radix = 10;
                alt   = 1'b0;
            end
            KIND_BIN: radix = 2;
            KIND_OCT: radix = 8;
            KIND_HEX: radix = 16;
            KIND_PTR: begin
                radix = 16;
                alt   = 1'b1;
            end
            default: return;
        endcase
        zpad  = r.zero_pad & ~r.left_justify;
        space = r.space_sign & ~r.plus_sign;

        mag = r.value;
        if (r.req_type == KIND_DEC && mag[VALUE_BITS-1]) begin
            neg = 1'b1;
            mag = -mag;
        end

        // Digits come out least significant first.
        rest = mag;
        while (rest != 0 && nsig < CHAR_CAP) begin
            digit_val = int'(rest % radix);
            if (digit_val < 10) begin
                digits[nsig] = CH_ZERO + 8'(digit_val);
            end else begin
                digits[nsig] = (r.caps ? CH_UP_A : CH_LO_A) + 8'(digit_val - 10);
            end
            nsig++;
            rest = rest / radix;
        end

        if (r.min_digits_given) begin
            zpad = 1'b0;
            nreq = (digs > nsig) ? digs : nsig;
        end else begin
            nreq = (nsig > 1) ? nsig : 1;
        end

        if (neg) begin
            p0     = CH_MINUS;
            nextra = 1;
        end else if (nreq == 0) begin
            nextra = 0;
        end else if (r.plus_sign) begin
            p0     = CH_PLUS;
            nextra = 1;
        end else if (space) begin
            p0     = CH_SPACE;
            nextra = 1;
        end else if (alt && mag != 0) begin
            p0 = CH_ZERO;
            if (radix == 2) begin
                p1     = r.caps ? CH_UP_B : CH_LO_B;
                nextra = 2;
            end else if (radix == 8) begin
                nextra = 1;
            end else begin
                p1     = r.caps ? CH_UP_X : CH_LO_X;
                nextra = 2;
            end
        end

        pad = width - nreq - nextra;

        if (!r.left_justify && !zpad) begin
            for (int i = 0; i < pad; i++) field_chars.push_back(CH_SPACE);
        end
        if (nextra >= 1) field_chars.push_back(p0);
        if (nextra >= 2) field_chars.push_back(p1);
        if (zpad) begin
            for (int i = 0; i < pad; i++) field_chars.push_back(CH_ZERO);
        end
        for (int i = 0; i < nreq - nsig; i++) field_chars.push_back(CH_ZERO);
        for (int i = nsig - 1; i >= 0; i--) field_chars.push_back(digits[i]);
        if (r.left_justify) begin
            for (int i = 0; i < pad; i++) field_chars.push_back(CH_SPACE);
        end

        n = (field_chars.size() > CHAR_CAP) ? CHAR_CAP : field_chars.size();
        for (int i = 0; i < n; i++) begin
            c.out_char = field_chars[i];
            c.last     = (i == n - 1);
            char_fifo.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                predict_chars(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (char_fifo.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("%0t: unexpected character %h last %b, none expected",
                                 $realtime, i_out_item.out_char, i_out_item.last);
                    end
                    fail_total++;
                end else begin
                    want = char_fifo.pop_front();
                    if (want.out_char !== i_out_item.out_char ||
                        want.last !== i_out_item.last) begin
                        if (fail_total < 10) begin
                            $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                                     $realtime, want.out_char, want.last,
                                     i_out_item.out_char, i_out_item.last);
                        end
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= char_fifo.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top of the integer field formatter: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top
    import ifmt_pkg::*;
;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 150;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in_item   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_res o_out_item;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    bit in_idle_off  = 1'b0;

    integer_field_formatter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    ifmt_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls at random, apart from one quiet window.
    always @(posedge i_clk) begin
        if (cycle_count >= 4000 && cycle_count < 9000) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 16);
        end
    end

    function automatic t_req basic_request(input logic [2:0] kind,
                                           input logic [VALUE_BITS-1:0] value);
        t_req r;
        r          = '0;
        r.req_type = kind;
        r.value    = value;
        return r;
    endfunction

    function automatic logic [5:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return 6'($urandom_range(0, 16));
        if (pick < 95) return 6'($urandom_range(0, 63));
        return $urandom_range(0, 1) ? 6'd63 : 6'd62;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r = '0;
        if ($urandom_range(0, 99) < 4) begin
            r.req_type = 3'($urandom_range(5, 7));
        end else begin
            r.req_type = 3'($urandom_range(0, 4));
        end
        pick = $urandom_range(0, 7);
        case (pick)
            0: r.value = '0;
            1: r.value = $urandom_range(0, 20);
            2: begin
                case ($urandom_range(0, 2))
                    0: r.value = 32'h8000_0000;
                    1: r.value = 32'hFFFF_FFFF;
                    default: r.value = 32'h7FFF_FFFF;
                endcase
            end
            3: r.value = -($urandom_range(1, 100));
            default: r.value = $urandom;
        endcase
        r.alt_prefix       = 1'($urandom_range(0, 1));
        r.zero_pad         = 1'($urandom_range(0, 1));
        r.left_justify     = 1'($urandom_range(0, 1));
        r.space_sign       = 1'($urandom_range(0, 1));
        r.plus_sign        = 1'($urandom_range(0, 1));
        r.caps             = 1'($urandom_range(0, 1));
        r.field_width      = random_size();
        r.min_digits       = random_size();
        r.min_digits_given = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input t_req r);
        if (!in_idle_off && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    initial begin
        t_req r;
        int   taken;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(basic_request(KIND_DEC, 32'd0));
        // Zero with no digits and no width gives an empty field.
        r = basic_request(KIND_DEC, 32'd0);
        r.min_digits_given = 1'b1;
        send_request(r);
        r.field_width = 6'd5;
        send_request(r);
        send_request(basic_request(KIND_DEC, 32'h8000_0000));
        r = basic_request(KIND_DEC, 32'h7FFF_FFFF);
        r.plus_sign = 1'b1;
        send_request(r);
        r = basic_request(KIND_DEC, 32'd123);
        r.space_sign = 1'b1;
        send_request(r);
        r.plus_sign = 1'b1;
        send_request(r);
        r = basic_request(KIND_DEC, -32'sd5);
        r.zero_pad    = 1'b1;
        r.field_width = 6'd8;
        send_request(r);
        r = basic_request(KIND_DEC, 32'd42);
        r.zero_pad     = 1'b1;
        r.left_justify = 1'b1;
        r.field_width  = 6'd10;
        send_request(r);
        r = basic_request(KIND_BIN, 32'hFFFF_FFFF);
        r.alt_prefix = 1'b1;
        r.caps       = 1'b1;
        send_request(r);
        r = basic_request(KIND_BIN, 32'd5);
        r.alt_prefix  = 1'b1;
        r.zero_pad    = 1'b1;
        r.field_width = 6'd12;
        send_request(r);
        r = basic_request(KIND_OCT, 32'd8);
        r.alt_prefix = 1'b1;
        send_request(r);
        r.value = '0;
        send_request(r);
        r = basic_request(KIND_HEX, 32'hDEAD_BEEF);
        r.alt_prefix = 1'b1;
        r.caps       = 1'b1;
        send_request(r);
        // A given digit count overrides zero padding.
        r = basic_request(KIND_HEX, 32'h0000_0ABC);
        r.min_digits       = 6'd8;
        r.min_digits_given = 1'b1;
        r.zero_pad         = 1'b1;
        r.field_width      = 6'd12;
        send_request(r);
        send_request(basic_request(KIND_PTR, 32'd0));
        r = basic_request(KIND_PTR, 32'h0000_1234);
        r.field_width  = 6'd63;
        r.left_justify = 1'b1;
        send_request(r);
        r = basic_request(KIND_HEX, 32'd1);
        r.min_digits       = 6'd63;
        r.min_digits_given = 1'b1;
        send_request(r);
        r = basic_request(KIND_BIN, 32'd0);
        r.min_digits_given = 1'b1;
        r.plus_sign        = 1'b1;
        send_request(r);
        for (int k = 5; k <= 7; k++) begin
            send_request(basic_request(3'(k), $urandom));
        end
        r = basic_request(KIND_HEX, 32'h0000_00FF);
        r.plus_sign = 1'b1;
        send_request(r);
        r = basic_request(KIND_DEC, 32'hFFFF_FFFF);
        r.field_width = 6'd63;
        r.zero_pad    = 1'b1;
        r.plus_sign   = 1'b1;
        send_request(r);
        r = basic_request(KIND_OCT, 32'hFFFF_FFFF);
        r.space_sign = 1'b1;
        send_request(r);

        // Random requests; undefined kinds are taken but do not count.
        taken = 0;
        while (taken < RANDOM_ITEMS) begin
            in_idle_off = (taken >= 70 && taken < 120);
            r = random_request();
            send_request(r);
            if (r.req_type <= KIND_PTR) taken++;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ifmt_pkg.sv
rtl/integer_field_formatter_top.sv
rtl/ifmt_checker.sv
tb/ifmt_checker.sv
tb/tb_top.sv
